/* design/fdtd_1d_field_step_unit_defines.svh */
// Assertion macros shared by the field step unit.
`ifndef FDTD_1D_FIELD_STEP_UNIT_DEFINES_SVH
`define FDTD_1D_FIELD_STEP_UNIT_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define FDTD_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("fdtd assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define FDTD_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("fdtd assertion failed");

`endif

/* design/fdtd_pkg.sv */
package fdtd_pkg;

   localparam int CELLS      = 256;
   localparam int ADDR_BITS  = $clog2(CELLS);
   localparam int VALUE_BITS = 24;
   localparam int COEF_FRAC  = 16;
   localparam int GAIN_BITS  = 17;
   localparam int LOSS_BITS  = 16;
   localparam int CELL_BITS  = 8;
   localparam int STEP_BITS  = 32;
   localparam int CSR_INDEX_BITS = 8;
   localparam int CSR_DATA_BITS  = 32;
   localparam int PROD_BITS  = VALUE_BITS + GAIN_BITS + 1;
   localparam int WIDE_BITS  = PROD_BITS + 1;

   typedef logic [ADDR_BITS-1:0]         addr_type;
   typedef logic signed [VALUE_BITS-1:0] value_type;
   typedef logic signed [WIDE_BITS-1:0]  wide_type;
   typedef logic signed [PROD_BITS-1:0]  prod_type;

   localparam addr_type LAST_ADDR = addr_type'(CELLS - 1);

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      REG_CELL_GAIN   = 8'd0,
      REG_LOSS_GAIN   = 8'd1,
      REG_SOURCE_CELL = 8'd2,
      REG_PROBE_CELL  = 8'd3
   } csr_index_type;

   typedef struct packed {
      logic     clear;
      logic     accept;
      logic     sweep_e;
      logic     edge_shift;
      logic     sweep_h;
      logic     load_out;
      addr_type addr;
   } cmd_type;

   typedef struct packed {
      logic busy;
   } status_type;

   function automatic wide_type widen(input value_type x);
      return WIDE_BITS'(x);
   endfunction

   function automatic value_type sat(input wide_type x);
      if ((&x[WIDE_BITS-1:VALUE_BITS-1]) || !(|x[WIDE_BITS-1:VALUE_BITS-1])) begin
         return x[VALUE_BITS-1:0];
      end else if (x[WIDE_BITS-1]) begin
         return {1'b1, {(VALUE_BITS-1){1'b0}}};
      end else begin
         return {1'b0, {(VALUE_BITS-1){1'b1}}};
      end
   endfunction

   function automatic value_type scale_down(input prod_type p);
      return sat(WIDE_BITS'(p >>> COEF_FRAC));
   endfunction

endpackage

/* design/fdtd_1d_field_step_unit.sv */
// One-dimensional Yee-grid field step over 256 cells with delayed-copy edges.
// Input channel req_: each accepted word carries one source sample (signed Q7.16)
// and advances the grid by one time step. Result channel rsp_: one word per step
// with E at the probe cell and the count of completed steps.
// Configuration channel csr_: index and data, taken whenever csr_valid is high;
// csr_ready is always high. Write only while the block is idle.
// A step runs from acceptance through a pass over the cells for D, E and I, a
// pipeline drain, a state that shifts the edge histories (an edge cell takes the
// E of its neighbour from two steps back), a pass over the cells for H, a second
// drain and the load of the output register; each pass takes one cell per cycle.
// The first edge at which the result word can be taken is also the first edge at
// which the next word can be accepted.
// Only one step is in flight; req_stall is high until the result is loaded.
// A finished result waits in the output register while rsp_stall is high; the
// next step may then run, and its result waits until the register is free.
// After reset the block clears the cell memories with req_stall high, and
// configuration writes are still taken during that time.
module fdtd_1d_field_step_unit
   import fdtd_pkg::*;
(
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic signed [VALUE_BITS-1:0]  req_source_sample,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic signed [VALUE_BITS-1:0]  rsp_probe_value,
   output logic [STEP_BITS-1:0]          rsp_step_index,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [CSR_INDEX_BITS-1:0]     csr_index,
   input  logic [CSR_DATA_BITS-1:0]      csr_data
);

   cmd_type    cmd;
   status_type status;

   assign csr_ready = 1'b1;

   fdtd_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .status    (status),
      .cmd       (cmd)
   );

   fdtd_datapath u_datapath (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .status            (status),
      .req_source_sample (req_source_sample),
      .csr_write         (csr_valid && csr_ready),
      .csr_index         (csr_index),
      .csr_data          (csr_data),
      .rsp_probe_value   (rsp_probe_value),
      .rsp_step_index    (rsp_step_index)
   );

endmodule

/* design/fdtd_ctrl.sv */
`include "fdtd_1d_field_step_unit_defines.svh"

module fdtd_ctrl
   import fdtd_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   input  status_type status,
   output cmd_type    cmd
);

   typedef enum logic [2:0] {
      S_CLEAR, S_IDLE, S_SWEEP_E, S_DRAIN_E, S_EDGE, S_SWEEP_H, S_DRAIN_H, S_REPLY
   } state_type;

   state_type state_ff, state_in;
   addr_type  addr_ff, addr_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      accept, load;

   assign req_stall = (state_ff != S_IDLE);
   assign accept    = req_valid && !req_stall;
   assign load      = (state_ff == S_REPLY) && !(rsp_valid_ff && rsp_stall);
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in = state_ff;
      addr_in  = addr_ff;
      unique case (state_ff)
         S_CLEAR: begin
            addr_in = addr_ff + 1'b1;
            if (addr_ff == LAST_ADDR) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            addr_in = '0;
            if (accept) begin
               state_in = S_SWEEP_E;
            end
         end
         S_SWEEP_E: begin
            addr_in = addr_ff + 1'b1;
            if (addr_ff == LAST_ADDR) begin
               state_in = S_DRAIN_E;
            end
         end
         S_DRAIN_E: begin
            if (!status.busy) begin
               state_in = S_EDGE;
            end
         end
         S_EDGE: begin
            addr_in  = '0;
            state_in = S_SWEEP_H;
         end
         S_SWEEP_H: begin
            addr_in = addr_ff + 1'b1;
            if (addr_ff == LAST_ADDR) begin
               state_in = S_DRAIN_H;
            end
         end
         S_DRAIN_H: begin
            if (!status.busy) begin
               state_in = S_REPLY;
            end
         end
         S_REPLY: begin
            if (load) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_comb begin
      if (load) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_comb begin
      cmd.clear      = (state_ff == S_CLEAR);
      cmd.accept     = accept;
      cmd.sweep_e    = (state_ff == S_SWEEP_E);
      cmd.edge_shift = (state_ff == S_EDGE);
      cmd.sweep_h    = (state_ff == S_SWEEP_H);
      cmd.load_out   = load;
      cmd.addr       = addr_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         addr_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         addr_ff      <= addr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   `FDTD_ASSERT_SAME(a_sweeps_exclusive, clock, reset, 1'b1, $onehot0({cmd.clear, cmd.sweep_e, cmd.sweep_h, cmd.edge_shift}))
   `FDTD_ASSERT_SAME(a_accept_when_drained, clock, reset, accept, !status.busy)
   `FDTD_ASSERT_SAME(a_edge_when_drained, clock, reset, cmd.edge_shift, !status.busy)
   `FDTD_ASSERT_NEXT(a_load_shows_word, clock, reset, load, rsp_valid_ff)

endmodule

/* design/fdtd_datapath.sv */
module fdtd_datapath
   import fdtd_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   input  cmd_type                   cmd,
   output status_type                status,
   input  logic signed [VALUE_BITS-1:0] req_source_sample,
   input  logic                      csr_write,
   input  logic [CSR_INDEX_BITS-1:0] csr_index,
   input  logic [CSR_DATA_BITS-1:0]  csr_data,
   output logic signed [VALUE_BITS-1:0] rsp_probe_value,
   output logic [STEP_BITS-1:0]      rsp_step_index
);

   value_type e_mem [CELLS];
   value_type h_mem [CELLS];
   value_type d_mem [CELLS];
   value_type i_mem [CELLS];

   logic [GAIN_BITS-1:0] cell_gain_ff;
   logic [LOSS_BITS-1:0] loss_gain_ff;
   logic [CELL_BITS-1:0] source_cell_ff;
   logic [CELL_BITS-1:0] probe_cell_ff;

   value_type e_q, h_q, d_q, i_q;
   value_type sample_ff, probe_ff, h_prev_ff, e_prev_ff;
   logic [STEP_BITS-1:0] step_ff;
   value_type out_probe_ff;
   logic [STEP_BITS-1:0] out_step_ff;

   logic      rv_e_ff, rv_h_ff;
   addr_type  rk_ff;
   logic      a_v_ff, b_v_ff, c_v_ff, w_v_ff;
   addr_type  a_k_ff, b_k_ff, c_k_ff, w_k_ff;
   value_type a_d_ff, a_i_ff, b_i_ff, c_i_ff, c_e_ff, w_h_ff;
   prod_type  b_prod_ff, c_prod_ff;

   value_type e1_ff, em_ff, e0_ff, en_ff, l0_ff, l1_ff, r0_ff, r1_ff;

   value_type src_add, d_src, d_new, diff, e_new, i_new, e_cur, h_new;

   always_ff @(posedge clock) begin
      if (reset) begin
         cell_gain_ff   <= GAIN_BITS'(65536);
         loss_gain_ff   <= '0;
         source_cell_ff <= CELL_BITS'(10);
         probe_cell_ff  <= '0;
      end else if (csr_write) begin
         priority case (csr_index)
            REG_CELL_GAIN:   cell_gain_ff   <= csr_data[GAIN_BITS-1:0];
            REG_LOSS_GAIN:   loss_gain_ff   <= csr_data[LOSS_BITS-1:0];
            REG_SOURCE_CELL: source_cell_ff <= csr_data[CELL_BITS-1:0];
            REG_PROBE_CELL:  probe_cell_ff  <= csr_data[CELL_BITS-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      e_q <= e_mem[cmd.addr];
      h_q <= h_mem[cmd.addr];
      d_q <= d_mem[cmd.addr];
      i_q <= i_mem[cmd.addr];
   end

   always_ff @(posedge clock) begin
      if (cmd.clear) begin
         d_mem[cmd.addr] <= '0;
      end else if (a_v_ff) begin
         d_mem[a_k_ff] <= a_d_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.clear) begin
         e_mem[cmd.addr] <= '0;
      end else if (c_v_ff) begin
         e_mem[c_k_ff] <= c_e_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.clear) begin
         i_mem[cmd.addr] <= '0;
      end else if (c_v_ff) begin
         i_mem[c_k_ff] <= i_new;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.clear) begin
         h_mem[cmd.addr] <= '0;
      end else if (w_v_ff) begin
         h_mem[w_k_ff] <= w_h_ff;
      end
   end

   always_comb begin
      src_add = (32'(source_cell_ff) == 32'(rk_ff)) ? sample_ff : '0;
      d_src   = sat(widen(d_q) + widen(src_add));
      d_new   = sat(widen(d_src) + ((widen(h_prev_ff) - widen(h_q)) >>> 1));
      diff    = sat(widen(a_d_ff) - widen(a_i_ff));
      e_new   = scale_down(b_prod_ff);
      i_new   = sat(widen(c_i_ff) + WIDE_BITS'(c_prod_ff >>> COEF_FRAC));
      if (rk_ff == '0) begin
         e_cur = e0_ff;
      end else if (rk_ff == LAST_ADDR) begin
         e_cur = en_ff;
      end else begin
         e_cur = e_q;
      end
      h_new = sat(widen(h_prev_ff) + ((widen(e_prev_ff) - widen(e_cur)) >>> 1));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rv_e_ff <= 1'b0;
         rv_h_ff <= 1'b0;
         a_v_ff  <= 1'b0;
         b_v_ff  <= 1'b0;
         c_v_ff  <= 1'b0;
         w_v_ff  <= 1'b0;
         step_ff <= '0;
         e1_ff   <= '0;
         em_ff   <= '0;
         e0_ff   <= '0;
         en_ff   <= '0;
         l0_ff   <= '0;
         l1_ff   <= '0;
         r0_ff   <= '0;
         r1_ff   <= '0;
      end else begin
         rv_e_ff <= cmd.sweep_e;
         rv_h_ff <= cmd.sweep_h;
         a_v_ff  <= rv_e_ff && (rk_ff != '0);
         b_v_ff  <= a_v_ff;
         c_v_ff  <= b_v_ff;
         w_v_ff  <= rv_h_ff && (rk_ff != '0);
         if (cmd.accept) begin
            step_ff <= step_ff + 1'b1;
         end
         if (c_v_ff && (c_k_ff == addr_type'(1))) begin
            e1_ff <= c_e_ff;
         end
         if (c_v_ff && (c_k_ff == addr_type'(CELLS - 2))) begin
            em_ff <= c_e_ff;
         end
         if (cmd.edge_shift) begin
            e0_ff <= l1_ff;
            l1_ff <= l0_ff;
            l0_ff <= e1_ff;
            en_ff <= r1_ff;
            r1_ff <= r0_ff;
            r0_ff <= em_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      rk_ff     <= cmd.addr;
      a_k_ff    <= rk_ff;
      a_d_ff    <= d_new;
      a_i_ff    <= i_q;
      b_k_ff    <= a_k_ff;
      b_i_ff    <= a_i_ff;
      b_prod_ff <= prod_type'(diff) * prod_type'($signed({1'b0, cell_gain_ff}));
      c_k_ff    <= b_k_ff;
      c_i_ff    <= b_i_ff;
      c_e_ff    <= e_new;
      c_prod_ff <= prod_type'(e_new) * prod_type'($signed({1'b0, loss_gain_ff}));
      w_k_ff    <= rk_ff - 1'b1;
      w_h_ff    <= h_new;
      if (cmd.accept) begin
         sample_ff <= req_source_sample;
         probe_ff  <= '0;
      end
      if (rv_e_ff || rv_h_ff) begin
         h_prev_ff <= h_q;
      end
      if (rv_h_ff) begin
         e_prev_ff <= e_cur;
         if (32'(probe_cell_ff) == 32'(rk_ff)) begin
            probe_ff <= e_cur;
         end
      end
      if (cmd.load_out) begin
         out_probe_ff <= probe_ff;
         out_step_ff  <= step_ff;
      end
   end

   assign status.busy     = rv_e_ff || rv_h_ff || a_v_ff || b_v_ff || c_v_ff || w_v_ff;
   assign rsp_probe_value = out_probe_ff;
   assign rsp_step_index  = out_step_ff;

endmodule

/* tb/fdtd_1d_field_step_unit_tb.sv */
`timescale 1ns / 100ps

module fdtd_1d_field_step_unit_tb;
   import fdtd_pkg::*;

   localparam int WATCHDOG_CYCLES = 20000;
   localparam int HOLD_CYCLES     = 3000;
   localparam longint VALUE_MAX   = (longint'(1) <<< (VALUE_BITS - 1)) - 1;
   localparam longint VALUE_MIN   = -VALUE_MAX - 1;

   typedef struct {
      value_type            probe_value;
      logic [STEP_BITS-1:0] step_index;
   } probe_word_type;

   logic                      clock;
   logic                      reset;
   logic                      req_valid;
   logic                      req_stall;
   value_type                 req_source_sample;
   logic                      rsp_valid;
   logic                      rsp_stall;
   value_type                 rsp_probe_value;
   logic [STEP_BITS-1:0]      rsp_step_index;
   logic                      csr_valid;
   logic                      csr_ready;
   logic [CSR_INDEX_BITS-1:0] csr_index;
   logic [CSR_DATA_BITS-1:0]  csr_data;

   longint e_field [CELLS];
   longint h_field [CELLS];
   longint d_field [CELLS];
   longint i_field [CELLS];
   longint left_hist [2];
   longint right_hist [2];
   logic [STEP_BITS-1:0] step_count;
   logic [GAIN_BITS-1:0] gain_reg;
   logic [LOSS_BITS-1:0] loss_reg;
   logic [CELL_BITS-1:0] source_reg;
   logic [CELL_BITS-1:0] probe_reg;

   probe_word_type pending_probes [$];
   int  mismatch_count;
   int  words_checked;
   int  samples_sent;
   int  idle_cycles;
   bit  timed_out;
   bit  hold_rsp;

   fdtd_1d_field_step_unit dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_source_sample (req_source_sample),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_probe_value   (rsp_probe_value),
      .rsp_step_index    (rsp_step_index),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_index         (csr_index),
      .csr_data          (csr_data)
   );

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   function automatic longint clamp(input longint x);
      if (x > VALUE_MAX) return VALUE_MAX;
      if (x < VALUE_MIN) return VALUE_MIN;
      return x;
   endfunction

   function automatic longint scale_by(input longint x, input longint c);
      return (x * c) >>> COEF_FRAC;
   endfunction

   function automatic void clear_grid();
      for (int k = 0; k < CELLS; k++) begin
         e_field[k] = 0;
         h_field[k] = 0;
         d_field[k] = 0;
         i_field[k] = 0;
      end
      left_hist = '{0, 0};
      right_hist = '{0, 0};
      step_count = '0;
      gain_reg = GAIN_BITS'(65536);
      loss_reg = '0;
      source_reg = CELL_BITS'(10);
      probe_reg = '0;
   endfunction

   function automatic probe_word_type advance_grid(input value_type sample);
      probe_word_type w;
      longint diff;
      d_field[source_reg] = clamp(d_field[source_reg] + longint'(sample));
      step_count = step_count + 1;
      for (int k = 1; k < CELLS; k++) begin
         d_field[k] = clamp(d_field[k] + ((h_field[k-1] - h_field[k]) >>> 1));
         diff = clamp(d_field[k] - i_field[k]);
         e_field[k] = clamp(scale_by(diff, longint'(gain_reg)));
         i_field[k] = clamp(i_field[k] + scale_by(e_field[k], longint'(loss_reg)));
      end
      e_field[0] = left_hist[1];
      left_hist[1] = left_hist[0];
      left_hist[0] = e_field[1];
      e_field[CELLS-1] = right_hist[1];
      right_hist[1] = right_hist[0];
      right_hist[0] = e_field[CELLS-2];
      for (int k = 0; k < CELLS - 1; k++) begin
         h_field[k] = clamp(h_field[k] + ((e_field[k] - e_field[k+1]) >>> 1));
      end
      w.probe_value = value_type'(e_field[probe_reg]);
      w.step_index = step_count;
      return w;
   endfunction

   task automatic write_csr(input logic [CSR_INDEX_BITS-1:0] idx,
                            input logic [CSR_DATA_BITS-1:0] data);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= data;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      case (idx)
         REG_CELL_GAIN:   gain_reg = data[GAIN_BITS-1:0];
         REG_LOSS_GAIN:   loss_reg = data[LOSS_BITS-1:0];
         REG_SOURCE_CELL: source_reg = data[CELL_BITS-1:0];
         REG_PROBE_CELL:  probe_reg = data[CELL_BITS-1:0];
         default: ;
      endcase
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic send_sample(input value_type sample);
      @(negedge clock);
      req_valid <= 1'b1;
      req_source_sample <= sample;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      pending_probes.push_back(advance_grid(sample));
      samples_sent++;
   endtask

   task automatic pause_sender();
      int n;
      n = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 700) : $urandom_range(0, 3);
      if (n > 0) begin
         @(negedge clock);
         req_valid <= 1'b0;
         repeat (n - 1) @(negedge clock);
      end
   endtask

   task automatic wait_drained();
      @(negedge clock);
      req_valid <= 1'b0;
      while (pending_probes.size() != 0) @(posedge clock);
   endtask

   function automatic value_type random_sample();
      int r;
      r = $urandom_range(0, 99);
      if (r < 70) return value_type'($signed($urandom_range(0, 8191)) - 4096);
      if (r < 80) return value_type'($signed($urandom_range(0, 262143)) - 131072);
      if (r < 90) return value_type'($urandom());
      if (r < 95) return value_type'(VALUE_MAX);
      return value_type'(VALUE_MIN);
   endfunction

   task automatic test_field_extremes();
      value_type edges [6];
      edges = '{value_type'(VALUE_MAX), value_type'(VALUE_MIN), '0,
                value_type'(1), value_type'(-1), value_type'(24'h555555)};
      foreach (edges[i]) begin
         send_sample(edges[i]);
         pause_sender();
      end
      wait_drained();
   endtask

   task automatic test_register_corners();
      write_csr(REG_SOURCE_CELL, 32'd0);
      write_csr(REG_PROBE_CELL, 32'd1);
      write_csr(REG_CELL_GAIN, 32'h1FFFF);
      write_csr(REG_LOSS_GAIN, 32'hFFFF);
      repeat (4) send_sample(value_type'(VALUE_MAX));
      wait_drained();
      write_csr(REG_SOURCE_CELL, 32'd255);
      write_csr(REG_PROBE_CELL, 32'd254);
      write_csr(REG_CELL_GAIN, 32'd0);
      repeat (3) send_sample(value_type'(VALUE_MIN));
      wait_drained();
      write_csr(REG_PROBE_CELL, 32'd255);
      write_csr(REG_CELL_GAIN, 32'hFFFE_0000 | 32'd65536);
      write_csr(CSR_INDEX_BITS'(4), 32'd7);
      write_csr(CSR_INDEX_BITS'(255), 32'hFFFF_FFFF);
      repeat (4) send_sample(value_type'(24'hAAAAAA));
      wait_drained();
   endtask

   task automatic test_random_phase(input int count, input logic [31:0] gain,
                                    input logic [31:0] loss);
      write_csr(REG_CELL_GAIN, gain);
      write_csr(REG_LOSS_GAIN, loss);
      write_csr(REG_SOURCE_CELL, $urandom_range(0, 255));
      write_csr(REG_PROBE_CELL, $urandom_range(0, 255));
      for (int i = 0; i < count; i++) begin
         send_sample(random_sample());
         if ($urandom_range(0, 49) == 0) begin
            wait_drained();
            write_csr(REG_PROBE_CELL, $urandom_range(0, 255));
         end else begin
            pause_sender();
         end
      end
      wait_drained();
   endtask

   task automatic test_output_backpressure();
      hold_rsp = 1'b1;
      for (int i = 0; i < 8; i++) send_sample(random_sample());
      wait_drained();
   endtask

   initial begin
      int v;
      int n;
      rsp_stall = 1'b0;
      @(negedge clock);
      forever begin
         if (hold_rsp) begin
            rsp_stall <= 1'b1;
            repeat (HOLD_CYCLES) @(negedge clock);
            hold_rsp = 1'b0;
         end else begin
            v = $urandom_range(0, 99);
            if (v < 50) begin
               rsp_stall <= 1'b0;
               n = 1;
            end else if (v < 85) begin
               rsp_stall <= 1'b1;
               n = $urandom_range(1, 3);
            end else if (v < 95) begin
               rsp_stall <= 1'b0;
               n = $urandom_range(20, 600);
            end else begin
               rsp_stall <= 1'b1;
               n = $urandom_range(50, 800);
            end
            repeat (n) @(negedge clock);
         end
      end
   end

   always @(posedge clock) begin
      probe_word_type w;
      if (!reset && rsp_valid && !rsp_stall) begin
         words_checked++;
         if (pending_probes.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10)
               $display("Unexpected result word: probe %0d step %0d",
                        rsp_probe_value, rsp_step_index);
         end else begin
            w = pending_probes.pop_front();
            if (rsp_probe_value !== w.probe_value || rsp_step_index !== w.step_index) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("Step %0d: expected probe %0d step %0d, got probe %0d step %0d",
                           w.step_index, w.probe_value, w.step_index,
                           rsp_probe_value, rsp_step_index);
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      wait (idle_cycles >= WATCHDOG_CYCLES);
      timed_out = 1'b1;
      $display("Mismatches found");
      $finish;
   end

   initial begin
      reset = 1'b1;
      req_valid = 1'b0;
      req_source_sample = '0;
      csr_valid = 1'b0;
      csr_index = '0;
      csr_data = '0;
      hold_rsp = 1'b0;
      timed_out = 1'b0;
      mismatch_count = 0;
      words_checked = 0;
      samples_sent = 0;
      idle_cycles = 0;
      clear_grid();
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_field_extremes();
      test_register_corners();
      test_output_backpressure();
      test_random_phase(250, 32'd65536, 32'd0);
      test_random_phase(250, 32'd65536, 32'd2000);
      test_random_phase(200, 32'd131071, 32'd65535);
      test_random_phase(150, 32'd0, $urandom_range(0, 65535));
      test_random_phase(280, $urandom_range(0, 131071), $urandom_range(0, 4000));
      repeat (600) @(posedge clock);
      $display("Sent %0d source samples and checked %0d result words.",
               samples_sent, words_checked);
      $display("Covered gain and loss extremes, edge cells, bad indexes and long stalls.");
      if (mismatch_count == 0 && pending_probes.size() == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule

/* filelist.f */
+incdir+design
design/fdtd_pkg.sv
design/fdtd_ctrl.sv
design/fdtd_datapath.sv
design/fdtd_1d_field_step_unit.sv
tb/fdtd_1d_field_step_unit_tb.sv
